[rtl/core/slpg_pkg.sv]
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types, codes and the breathing ROM for the status LED pattern
// generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  localparam int unsigned BREATH_TABLE_DEPTH = 256;
  localparam int unsigned DUTY_BITS          = 8;
  localparam int unsigned IDX_W              = $clog2(BREATH_TABLE_DEPTH);

  localparam int unsigned TIME_WRAP = 2000;
  localparam int unsigned HALF_WRAP = TIME_WRAP / 2;
  localparam int unsigned TIME_W    = $clog2(TIME_WRAP);
  // phase remainder accumulators, one spare bit for the carry check
  localparam int unsigned ACC_W     = TIME_W + 1;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // request codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MODE = 1'b1;

  // display modes; codes above MODE_FLASH_FAST behave as off
  localparam logic [MODE_W-1:0] MODE_OFF          = 4'd0;
  localparam logic [MODE_W-1:0] MODE_BLINK_SLOW   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK_FAST   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIM          = 4'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH_DIM    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BREATH_SLOW  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_BREATH_FAST  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_FLASH_SLOW   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_FLASH_FAST   = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_UPDATE = 3'd5;

  typedef struct packed {
    logic [DUTY_BITS-1:0] dim_level;
    logic [DUTY_BITS-1:0] flash_level;
    logic [TICK_W-1:0]    slow_blink_ticks;
    logic [TICK_W-1:0]    fast_blink_ticks;
    logic [TICK_W-1:0]    flash_ticks;
    logic [TICK_W-1:0]    breath_update_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dim_level:           8'd50,
    flash_level:         8'd255,
    slow_blink_ticks:    16'd400,
    fast_blink_ticks:    16'd100,
    flash_ticks:         16'd250,
    breath_update_ticks: 16'd40
  };

  // Q28 fixed point for the ROM build
  localparam int unsigned      QF        = 28;
  localparam longint unsigned  ONE_Q     = 64'd1 << QF;
  localparam longint unsigned  PI_Q      = 64'd843314857;
  localparam longint unsigned  TWO_PI_Q  = 64'd1686629713;
  localparam longint unsigned  HALF_PI_Q = PI_Q / 2;

  typedef logic [BREATH_TABLE_DEPTH-1:0][DUTY_BITS-1:0] breath_rom_t;

  // truncating quotient by shift and subtract, elaboration only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // exp(sin(2*pi*i/D)) scaled to 0..100, evaluated at elaboration only
  function automatic logic [DUTY_BITS-1:0] breath_entry(int unsigned i);
    longint unsigned d;
    longint unsigned mag;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned e;
    longint unsigned num;
    longint unsigned sub;
    longint unsigned v;
    longint          acc;
    bit              neg;
    d   = longint'(BREATH_TABLE_DEPTH);
    neg = (2 * i >= d) && (2 * i != d);
    if (2 * i == d) begin
      mag = 0;
    end else if (!neg) begin
      mag = udiv64(longint'(i) * TWO_PI_Q, d);
    end else begin
      mag = udiv64((d - longint'(i)) * TWO_PI_Q, d);
    end
    if (mag > HALF_PI_Q) begin
      mag = (mag >= PI_Q) ? 64'd0 : PI_Q - mag;
    end
    x2   = (mag * mag) >> QF;
    term = mag;
    acc  = longint'(mag);
    for (int n = 1; n <= 5; n++) begin
      term = udiv64((term * x2) >> QF, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q)) begin
      acc = longint'(ONE_Q);
    end
    e    = ONE_Q;
    term = ONE_Q;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * longint'(acc)) >> QF, 64'(n));
      e    = e + term;
    end
    if (neg) begin
      e = udiv64(64'd1 << 56, e);
    end
    num = e * 64'd1000;
    sub = 64'd368 << QF;
    if (num <= sub) begin
      return '0;
    end
    v = udiv64((num - sub) * 64'd42546, 64'd1000000 << QF);
    return (v > 64'd255) ? 8'd255 : v[DUTY_BITS-1:0];
  endfunction

  function automatic breath_rom_t build_breath_rom();
    breath_rom_t rom;
    for (int unsigned i = 0; i < BREATH_TABLE_DEPTH; i++) begin
      rom[i] = breath_entry(i);
    end
    return rom;
  endfunction

  localparam breath_rom_t BREATH_ROM = build_breath_rom();

endpackage

[rtl/core/slpg_if.sv]
// ----------------------------------------------------------------------------
// slpg_if
// Valid/ready channels of the status LED pattern generator: request,
// duty result and configuration write.
// ----------------------------------------------------------------------------
interface slpg_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [slpg_pkg::MODE_W-1:0]      new_mode;

  modport source (output valid, output cmd, output new_mode, input ready);
  modport sink   (input valid, input cmd, input new_mode, output ready);
endinterface

interface slpg_out_if;
  logic                             valid;
  logic                             ready;
  logic [slpg_pkg::DUTY_BITS-1:0]   duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

interface slpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slpg_pkg::CFG_IDX_W-1:0]   index;
  logic [slpg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/slpg_core.sv]
// ----------------------------------------------------------------------------
// slpg_core
// Mode state, interval counter, millisecond phase tracking and duty
// register. One request is applied per cycle when fire_i is high.
// ----------------------------------------------------------------------------
module slpg_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic                              cmd_i,
  input  logic [slpg_pkg::MODE_W-1:0]       new_mode_i,
  input  slpg_pkg::cfg_t                    cfg_i,
  output logic [slpg_pkg::DUTY_BITS-1:0]    duty_o
);

  localparam int unsigned TW = slpg_pkg::TIME_W;
  localparam int unsigned AW = slpg_pkg::ACC_W;
  localparam int unsigned IW = slpg_pkg::IDX_W;
  localparam int unsigned MW = slpg_pkg::MODE_W;
  localparam int unsigned DW = slpg_pkg::DUTY_BITS;
  localparam int unsigned KW = slpg_pkg::TICK_W;

  localparam logic [TW-1:0] TIME_LAST = TW'(slpg_pkg::TIME_WRAP - 1);
  localparam logic [TW-1:0] TIME_HALF = TW'(slpg_pkg::HALF_WRAP);
  localparam logic [AW-1:0] WRAP_A    = AW'(slpg_pkg::TIME_WRAP);
  localparam logic [AW-1:0] STEP_S    = AW'(slpg_pkg::BREATH_TABLE_DEPTH);
  localparam logic [AW:0]   STEP_F    = (AW+1)'(2 * slpg_pkg::BREATH_TABLE_DEPTH);
  localparam logic [AW:0]   WRAP_F1   = (AW+1)'(slpg_pkg::TIME_WRAP);
  localparam logic [AW:0]   WRAP_F2   = (AW+1)'(2 * slpg_pkg::TIME_WRAP);

  logic [MW-1:0] mode_q,  mode_d;
  logic [KW-1:0] cnt_q,   cnt_d;
  logic          blink_q, blink_d;
  logic [DW-1:0] duty_q,  duty_d;
  logic [TW-1:0] time_q,  time_d;
  // slow phase: sidx*2000 + sacc == time*D; fast phase likewise for 2*time mod 2000
  logic [IW-1:0] sidx_q,  sidx_d;
  logic [AW-1:0] sacc_q,  sacc_d;
  logic [IW-1:0] fidx_q,  fidx_d;
  logic [AW-1:0] facc_q,  facc_d;

  logic          tick;
  logic [AW-1:0] sacc_sum;
  logic [AW:0]   facc_sum;
  logic [DW-1:0] sample_slow;
  logic [DW-1:0] sample_fast;
  logic [KW:0]   cnt_inc;
  logic [KW-1:0] period;
  logic          period_done;
  logic          enter_en;
  logic [MW-1:0] enter_mode;

  assign tick = fire_i && (cmd_i == slpg_pkg::CMD_TICK);

  // millisecond counter and table phase
  always_comb begin
    time_d   = time_q;
    sidx_d   = sidx_q;
    sacc_d   = sacc_q;
    fidx_d   = fidx_q;
    facc_d   = facc_q;
    sacc_sum = sacc_q + STEP_S;
    facc_sum = {1'b0, facc_q} + STEP_F;
    if (tick) begin
      if (time_q == TIME_LAST) begin
        time_d = '0;
        sidx_d = '0;
        sacc_d = '0;
      end else begin
        time_d = time_q + TW'(1);
        if (sacc_sum >= WRAP_A) begin
          sacc_d = sacc_sum - WRAP_A;
          sidx_d = sidx_q + IW'(1);
        end else begin
          sacc_d = sacc_sum;
        end
      end
      if (time_q == TIME_LAST || time_d == TIME_HALF) begin
        fidx_d = '0;
        facc_d = '0;
      end else if (facc_sum >= WRAP_F2) begin
        facc_d = AW'(facc_sum - WRAP_F2);
        fidx_d = fidx_q + IW'(2);
      end else if (facc_sum >= WRAP_F1) begin
        facc_d = AW'(facc_sum - WRAP_F1);
        fidx_d = fidx_q + IW'(1);
      end else begin
        facc_d = facc_sum[AW-1:0];
      end
    end
  end

  assign sample_slow = slpg_pkg::BREATH_ROM[sidx_d];
  assign sample_fast = slpg_pkg::BREATH_ROM[fidx_d];

  always_comb begin
    case (mode_q)
      slpg_pkg::MODE_BLINK_SLOW:  period = cfg_i.slow_blink_ticks;
      slpg_pkg::MODE_BLINK_FAST:  period = cfg_i.fast_blink_ticks;
      slpg_pkg::MODE_FLASH_DIM,
      slpg_pkg::MODE_FLASH_SLOW,
      slpg_pkg::MODE_FLASH_FAST:  period = cfg_i.flash_ticks;
      default:                    period = cfg_i.breath_update_ticks;
    endcase
  end

  assign cnt_inc     = {1'b0, cnt_q} + (KW+1)'(1);
  assign period_done = (cnt_inc >= {1'b0, period});

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    blink_d    = blink_q;
    duty_d     = duty_q;
    enter_en   = 1'b0;
    enter_mode = mode_q;
    if (fire_i) begin
      if (cmd_i == slpg_pkg::CMD_MODE) begin
        if (new_mode_i != mode_q) begin
          enter_en   = 1'b1;
          enter_mode = new_mode_i;
        end
      end else begin
        case (mode_q)
          slpg_pkg::MODE_BLINK_SLOW,
          slpg_pkg::MODE_BLINK_FAST: begin
            if (period_done) begin
              cnt_d   = '0;
              blink_d = ~blink_q;
              duty_d  = blink_q ? '0 : cfg_i.dim_level;
            end else begin
              cnt_d = cnt_inc[KW-1:0];
            end
          end
          slpg_pkg::MODE_FLASH_DIM,
          slpg_pkg::MODE_FLASH_SLOW,
          slpg_pkg::MODE_FLASH_FAST: begin
            if (period_done) begin
              enter_en = 1'b1;
              if (mode_q == slpg_pkg::MODE_FLASH_DIM) begin
                enter_mode = slpg_pkg::MODE_DIM;
              end else if (mode_q == slpg_pkg::MODE_FLASH_SLOW) begin
                enter_mode = slpg_pkg::MODE_BREATH_SLOW;
              end else begin
                enter_mode = slpg_pkg::MODE_BREATH_FAST;
              end
            end else begin
              cnt_d = cnt_inc[KW-1:0];
            end
          end
          slpg_pkg::MODE_BREATH_SLOW,
          slpg_pkg::MODE_BREATH_FAST: begin
            if (period_done) begin
              cnt_d  = '0;
              duty_d = (mode_q == slpg_pkg::MODE_BREATH_FAST) ? sample_fast : sample_slow;
            end else begin
              cnt_d = cnt_inc[KW-1:0];
            end
          end
          default: ;
        endcase
      end
    end
    // entering a mode drops any pending flash return
    if (enter_en) begin
      mode_d  = enter_mode;
      cnt_d   = '0;
      blink_d = 1'b0;
      case (enter_mode)
        slpg_pkg::MODE_BLINK_SLOW,
        slpg_pkg::MODE_BLINK_FAST: begin
          blink_d = 1'b1;
          duty_d  = cfg_i.dim_level;
        end
        slpg_pkg::MODE_DIM:         duty_d = cfg_i.dim_level;
        slpg_pkg::MODE_FLASH_DIM,
        slpg_pkg::MODE_FLASH_SLOW,
        slpg_pkg::MODE_FLASH_FAST:  duty_d = cfg_i.flash_level;
        slpg_pkg::MODE_BREATH_SLOW: duty_d = sample_slow;
        slpg_pkg::MODE_BREATH_FAST: duty_d = sample_fast;
        default:                    duty_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= slpg_pkg::MODE_OFF;
      cnt_q   <= '0;
      blink_q <= 1'b0;
      duty_q  <= '0;
      time_q  <= '0;
      sidx_q  <= '0;
      sacc_q  <= '0;
      fidx_q  <= '0;
      facc_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      blink_q <= blink_d;
      duty_q  <= duty_d;
      time_q  <= time_d;
      sidx_q  <= sidx_d;
      sacc_q  <= sacc_d;
      fidx_q  <= fidx_d;
      facc_q  <= facc_d;
    end
  end

  assign duty_o = duty_q;

endmodule

[rtl/core/status_led_pattern_generator.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// PWM duty generator for a status LED driven by mode requests and
// millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one request per item. cmd = 0 is a 1 ms tick, cmd = 1 sets the
//            display mode from new_mode (a repeat of the current mode is
//            a no-op).
//   rsp_o  : exactly one duty result per request, in request order.
//   cfg_i  : register writes (index 0..5), always ready; write only while
//            no request is in flight. Other indexes are dropped.
// Timing: a request is registered in the input register on acceptance,
//   then applied into the core's duty register, which drives rsp_o.
//   One request per cycle is sustained while rsp_o is not held; the state
//   update is a single combinational pass (counter compare plus a breathing
//   ROM read) into the result register.
// Stall: while rsp_o is held, one more request is taken into the input
//   register, then req_i.ready drops until the result is taken.
// Reset: mode off, duty 0, time and interval counters zero, registers at
//   their defaults. The breathing ROM is constant, no clearing pass.
// ----------------------------------------------------------------------------
module status_led_pattern_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  slpg_in_if.sink          req_i,
  slpg_out_if.source       rsp_o,
  slpg_cfg_if.sink         cfg_i
);

  logic                               in_valid_q;
  logic                               in_cmd_q;
  logic [slpg_pkg::MODE_W-1:0]        in_mode_q;
  logic                               out_valid_q;
  logic                               advance;
  slpg_pkg::cfg_t                     cfg_q;
  logic [slpg_pkg::DUTY_BITS-1:0]     duty;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_cmd_q  <= req_i.cmd;
      in_mode_q <= req_i.new_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= slpg_pkg::CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        slpg_pkg::REG_DIM_LEVEL:
          cfg_q.dim_level <= cfg_i.data[slpg_pkg::DUTY_BITS-1:0];
        slpg_pkg::REG_FLASH_LEVEL:
          cfg_q.flash_level <= cfg_i.data[slpg_pkg::DUTY_BITS-1:0];
        slpg_pkg::REG_SLOW_BLINK:    cfg_q.slow_blink_ticks    <= cfg_i.data;
        slpg_pkg::REG_FAST_BLINK:    cfg_q.fast_blink_ticks    <= cfg_i.data;
        slpg_pkg::REG_FLASH_TICKS:   cfg_q.flash_ticks         <= cfg_i.data;
        slpg_pkg::REG_BREATH_UPDATE: cfg_q.breath_update_ticks <= cfg_i.data;
        default: ;
      endcase
    end
  end

  slpg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .cmd_i      (in_cmd_q),
    .new_mode_i (in_mode_q),
    .cfg_i      (cfg_q),
    .duty_o     (duty)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.duty  = duty;

endmodule

[rtl/core/slpg_checker.sv]
// ----------------------------------------------------------------------------
// slpg_checker
// Port-level checks of the status LED pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module slpg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [slpg_pkg::DUTY_BITS-1:0]   out_duty,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // a stalled result holds its duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_duty))
    else $error("stalled duty result changed or dropped");

  // every accepted request is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result after accepted request");

  // one request buffered behind a stalled result, then backpressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid && in_ready && out_valid && !out_ready) && out_valid && !out_ready
      |-> !in_ready)
    else $error("request taken with no room behind stalled result");

  // configuration writes never wait, even alongside requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && (in_valid || out_valid) |-> cfg_ready)
    else $error("configuration write not ready");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .out_duty  (rsp_o.duty),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

[tb/tb_status_led_pattern_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_pattern_generator
// Self-checking bench for the status LED pattern generator. Mode and tick
// requests go in under several register settings. A cycle model of the
// duty logic, with its own exp(sin) breathing table, predicts every result.
// Each duty that comes back is compared in order against that prediction.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_generator;

  typedef longint unsigned u64_t;

  localparam int unsigned MS_WRAP    = 2000;
  localparam int unsigned FX_SHIFT   = 28;
  localparam u64_t        FX_ONE     = u64_t'(1) << FX_SHIFT;
  localparam u64_t        FX_PI      = 64'd843314857;
  localparam u64_t        FX_TWO_PI  = 64'd1686629713;
  localparam u64_t        FX_HALF_PI = FX_PI / 2;

  // codes above the last defined mode act as off
  localparam logic [slpg_pkg::MODE_W-1:0] MODE_UNKNOWN_LO = 4'd9;
  localparam logic [slpg_pkg::MODE_W-1:0] MODE_UNKNOWN_HI = 4'd15;

  localparam int unsigned RSP_HOLD_CYCLES = 100;

  class led_duty_scoreboard;
    logic [7:0]  dim_level;
    logic [7:0]  flash_level;
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [15:0] flash_period;
    logic [15:0] breath_period;
    logic [3:0]  mode;
    logic [15:0] interval_count;
    bit          blink_on;
    logic [7:0]  duty;
    int unsigned ms_count;
    logic [7:0]  exp_sin_rom [slpg_pkg::BREATH_TABLE_DEPTH];
    logic [7:0]  expected_duty [$];
    int unsigned results_seen;
    int unsigned error_count;

    function new();
      for (int unsigned i = 0; i < slpg_pkg::BREATH_TABLE_DEPTH; i++) begin
        exp_sin_rom[i] = exp_sin_level(i);
      end
      dim_level      = 8'd50;
      flash_level    = 8'd255;
      slow_period    = 16'd400;
      fast_period    = 16'd100;
      flash_period   = 16'd250;
      breath_period  = 16'd40;
      mode           = slpg_pkg::MODE_OFF;
      interval_count = '0;
      blink_on       = 1'b0;
      duty           = '0;
      ms_count       = 0;
      results_seen   = 0;
      error_count    = 0;
    endfunction

    // Q28 fixed point: Taylor sin, then Taylor exp of |sin|, scaled to 0..100
    function logic [7:0] exp_sin_level(int unsigned i);
      u64_t    depth;
      u64_t    ang;
      u64_t    sq;
      u64_t    term;
      u64_t    ex;
      u64_t    num;
      u64_t    offs;
      u64_t    lvl;
      longint  s;
      bit      falling;
      depth   = u64_t'(slpg_pkg::BREATH_TABLE_DEPTH);
      falling = (2 * i >= depth) && (2 * i != depth);
      if (2 * i == depth) begin
        ang = 0;
      end else if (!falling) begin
        ang = (u64_t'(i) * FX_TWO_PI) / depth;
      end else begin
        ang = ((depth - u64_t'(i)) * FX_TWO_PI) / depth;
      end
      if (ang > FX_HALF_PI) begin
        ang = (ang >= FX_PI) ? 0 : FX_PI - ang;
      end
      sq   = (ang * ang) >> FX_SHIFT;
      term = ang;
      s    = longint'(ang);
      for (int k = 1; k <= 5; k++) begin
        term = ((term * sq) >> FX_SHIFT) / u64_t'(2 * k * (2 * k + 1));
        if (k % 2 == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      if (s > longint'(FX_ONE)) begin
        s = longint'(FX_ONE);
      end
      ex   = FX_ONE;
      term = FX_ONE;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * u64_t'(s)) >> FX_SHIFT) / u64_t'(k);
        ex   = ex + term;
      end
      // negative half of the sine: exp(-x) = 1 / exp(x)
      if (falling) begin
        ex = (u64_t'(1) << 56) / ex;
      end
      num  = ex * 64'd1000;
      offs = u64_t'(368) << FX_SHIFT;
      if (num <= offs) begin
        return '0;
      end
      lvl = ((num - offs) * 64'd42546) / (u64_t'(1000000) << FX_SHIFT);
      return (lvl > 64'd255) ? 8'd255 : lvl[7:0];
    endfunction

    function logic [7:0] breath_level(logic [3:0] m);
      int unsigned t;
      int unsigned idx;
      t = ms_count;
      if (m == slpg_pkg::MODE_BREATH_FAST) begin
        t = (2 * t) % MS_WRAP;
      end
      idx = (t * slpg_pkg::BREATH_TABLE_DEPTH) / MS_WRAP;
      if (idx >= slpg_pkg::BREATH_TABLE_DEPTH) begin
        idx = slpg_pkg::BREATH_TABLE_DEPTH - 1;
      end
      return exp_sin_rom[idx];
    endfunction

    function void enter_mode(logic [3:0] m);
      mode           = m;
      interval_count = '0;
      blink_on       = 1'b0;
      case (m)
        slpg_pkg::MODE_BLINK_SLOW, slpg_pkg::MODE_BLINK_FAST: begin
          blink_on = 1'b1;
          duty     = dim_level;
        end
        slpg_pkg::MODE_DIM: begin
          duty = dim_level;
        end
        slpg_pkg::MODE_FLASH_DIM, slpg_pkg::MODE_FLASH_SLOW,
        slpg_pkg::MODE_FLASH_FAST: begin
          duty = flash_level;
        end
        slpg_pkg::MODE_BREATH_SLOW, slpg_pkg::MODE_BREATH_FAST: begin
          duty = breath_level(m);
        end
        default: begin
          duty = '0;
        end
      endcase
    endfunction

    function bit interval_done(logic [15:0] period);
      int unsigned c;
      c = interval_count + 1;
      if (c >= period) begin
        interval_count = '0;
        return 1'b1;
      end
      interval_count = c[15:0];
      return 1'b0;
    endfunction

    function void set_register(logic [slpg_pkg::CFG_IDX_W-1:0] idx,
                               logic [slpg_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        slpg_pkg::REG_DIM_LEVEL:     dim_level     = val[7:0];
        slpg_pkg::REG_FLASH_LEVEL:   flash_level   = val[7:0];
        slpg_pkg::REG_SLOW_BLINK:    slow_period   = val;
        slpg_pkg::REG_FAST_BLINK:    fast_period   = val;
        slpg_pkg::REG_FLASH_TICKS:   flash_period  = val;
        slpg_pkg::REG_BREATH_UPDATE: breath_period = val;
        default: ;
      endcase
    endfunction

    function void note_request(logic c, logic [3:0] m);
      if (c == slpg_pkg::CMD_MODE) begin
        if (m != mode) begin
          enter_mode(m);
        end
      end else begin
        ms_count = (ms_count + 1) % MS_WRAP;
        case (mode)
          slpg_pkg::MODE_BLINK_SLOW, slpg_pkg::MODE_BLINK_FAST: begin
            if (interval_done(mode == slpg_pkg::MODE_BLINK_SLOW ? slow_period
                                                                : fast_period)) begin
              blink_on = !blink_on;
              duty     = blink_on ? dim_level : 8'd0;
            end
          end
          slpg_pkg::MODE_FLASH_DIM, slpg_pkg::MODE_FLASH_SLOW,
          slpg_pkg::MODE_FLASH_FAST: begin
            if (interval_done(flash_period)) begin
              enter_mode(mode == slpg_pkg::MODE_FLASH_DIM  ? slpg_pkg::MODE_DIM :
                         mode == slpg_pkg::MODE_FLASH_SLOW ? slpg_pkg::MODE_BREATH_SLOW :
                                                             slpg_pkg::MODE_BREATH_FAST);
            end
          end
          slpg_pkg::MODE_BREATH_SLOW, slpg_pkg::MODE_BREATH_FAST: begin
            if (interval_done(breath_period)) begin
              duty = breath_level(mode);
            end
          end
          default: ;
        endcase
      end
      expected_duty.push_back(duty);
    endfunction

    function void note_failure(string msg);
      error_count++;
      if (error_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_duty(logic [7:0] got);
      logic [7:0] want;
      results_seen++;
      if (expected_duty.size() == 0) begin
        note_failure($sformatf("result %0d: duty %0d with no request pending",
                               results_seen, got));
      end else begin
        want = expected_duty.pop_front();
        if (got !== want) begin
          note_failure($sformatf("result %0d: duty expected %0d, got %0d",
                                 results_seen, want, got));
        end
      end
    endfunction

    function void check_drained();
      if (expected_duty.size() != 0) begin
        note_failure($sformatf("%0d duty results never arrived", expected_duty.size()));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  slpg_in_if  req_bus ();
  slpg_out_if rsp_bus ();
  slpg_cfg_if cfg_bus ();

  led_duty_scoreboard sb;
  bit                 rsp_hold_req = 1'b0;

  status_led_pattern_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshake monitor: feeds the model and checks results at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.set_register(cfg_bus.index, cfg_bus.data);
      end
      if (req_bus.valid && req_bus.ready) begin
        sb.note_request(req_bus.cmd, req_bus.new_mode);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_duty(rsp_bus.duty);
      end
    end
  end

  // result side: changing stall pattern, plus one long hold on request
  initial begin : rsp_side
    int unsigned cyc;
    int unsigned style;
    int unsigned hold;
    cyc   = 0;
    style = 0;
    hold  = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold         = RSP_HOLD_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        rsp_bus.ready <= 1'b0;
      end else begin
        cyc++;
        if (cyc % 150 == 0) begin
          style = $urandom_range(0, 3);
        end
        case (style)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_bus.ready <= ($urandom_range(0, 1) != 0);
          default: rsp_bus.ready <= (cyc % 7 < 3);
        endcase
      end
    end
  end

  task automatic push_request(input logic c, input logic [3:0] m, input int unsigned gap);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.cmd      <= c;
    req_bus.new_mode <= m;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic write_register(input logic [slpg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [slpg_pkg::CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] dim, input logic [7:0] flash,
                                input logic [15:0] slow, input logic [15:0] fast,
                                input logic [15:0] flash_len, input logic [15:0] breath);
    write_register(slpg_pkg::REG_DIM_LEVEL, {8'd0, dim});
    write_register(slpg_pkg::REG_FLASH_LEVEL, {8'd0, flash});
    write_register(slpg_pkg::REG_SLOW_BLINK, slow);
    write_register(slpg_pkg::REG_FAST_BLINK, fast);
    write_register(slpg_pkg::REG_FLASH_TICKS, flash_len);
    write_register(slpg_pkg::REG_BREATH_UPDATE, breath);
  endtask

  // stop offering, let every pending duty drain, then a few quiet cycles;
  // the first edge lets the monitor record the last accepted request
  task automatic finish_phase();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_duty.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_period();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(13, 600));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // mostly ticks between mode changes so blinks, flashes and breaths run on
  task automatic run_random_phase(input int unsigned n_items, input bit with_hold);
    int unsigned burst_left;
    int unsigned gap;
    int unsigned pick;
    logic        c;
    logic [3:0]  m;
    burst_left = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 8);
        end
      end
      burst_left--;
      if (with_hold && k == n_items / 2) begin
        rsp_hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        c = slpg_pkg::CMD_TICK;
        m = 4'($urandom);
      end else if (pick < 95) begin
        c = slpg_pkg::CMD_MODE;
        m = 4'($urandom_range(slpg_pkg::MODE_OFF, slpg_pkg::MODE_FLASH_FAST));
      end else begin
        c = slpg_pkg::CMD_MODE;
        m = 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
      end
      push_request(c, m, gap);
    end
    finish_phase();
  endtask

  initial begin : stimulus
    rst_ni           <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.cmd      <= slpg_pkg::CMD_TICK;
    req_bus.new_mode <= slpg_pkg::MODE_OFF;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= slpg_pkg::REG_DIM_LEVEL;
    cfg_bus.data     <= '0;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset levels seen through mode entries; repeat of off is ignored
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_OFF, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BLINK_SLOW, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_DIM, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_DIM, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BREATH_SLOW, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BREATH_FAST, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_FAST, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_SLOW, 0);
    finish_phase();

    // short periods: toggles, flash return, cancelled return, unknown codes
    apply_settings(8'd90, 8'd165, 16'd2, 16'd1, 16'd2, 16'd1);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BLINK_SLOW, 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BLINK_SLOW, 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_BLINK_FAST, 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_DIM, 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_SLOW, 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, slpg_pkg::MODE_FLASH_FAST, 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_TICK, 4'($urandom), 0);
    push_request(slpg_pkg::CMD_MODE, MODE_UNKNOWN_LO, 0);
    push_request(slpg_pkg::CMD_MODE, MODE_UNKNOWN_HI, 0);
    finish_phase();

    apply_settings(8'd0, 8'd255, 16'd1, 16'd1, 16'd1, 16'd1);
    run_random_phase(160, 1'b0);
    apply_settings(8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_phase(120, 1'b0);
    // zero periods: every tick acts
    apply_settings(8'($urandom), 8'($urandom), 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_phase(160, 1'b0);
    for (int p = 0; p < 5; p++) begin
      apply_settings(8'($urandom), 8'($urandom), random_period(), random_period(),
                     random_period(), random_period());
      run_random_phase(170, p == 1);
    end

    repeat (8) @(posedge clk_i);
    sb.check_drained();
    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[status_led_pattern_generator.f]
rtl/core/slpg_pkg.sv
rtl/core/slpg_if.sv
rtl/core/slpg_core.sv
rtl/core/status_led_pattern_generator.sv
rtl/core/slpg_checker.sv
tb/tb_status_led_pattern_generator.sv
